FILE: hw/rtl/rom_bank_mapper_with_cart_ram_top_defines.svh
// Assertion macros for the ROM bank mapper.
// Included by the top level; depends on signals named clk and rst_n in scope.
`ifndef ROM_BANK_MAPPER_WITH_CART_RAM_TOP_DEFINES_SVH
`define ROM_BANK_MAPPER_WITH_CART_RAM_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RBM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rom bank mapper: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rom bank mapper: next-cycle check failed");

`endif

FILE: hw/rtl/rbm_pkg.sv
// Shared types and constants of the ROM bank mapper.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package rbm_pkg;

    // Field widths of the bus access and of the decoded result.
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int BANK_W      = 4;
    localparam int BANK_BYTES  = 16384;
    localparam int BANK_OFS_W  = $clog2(BANK_BYTES);
    localparam int MEM_ADDR_W  = BANK_W + BANK_OFS_W;
    localparam int TARGET_W    = 3;

    // Cartridge RAM geometry.
    localparam int RAM_DEPTH   = 512;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);

    // Address map.
    localparam logic [ADDR_W-1:0] BANK_SEL_BASE = 16'h2000;
    localparam logic [ADDR_W-1:0] ROM_WIN_BASE  = 16'h4000;
    localparam logic [ADDR_W-1:0] ROM_WIN_END   = 16'h8000;
    localparam logic [ADDR_W-1:0] CART_BASE     = 16'hA000;
    localparam logic [ADDR_W-1:0] ECHO_BASE     = 16'hE000;
    localparam logic [ADDR_W-1:0] ECHO_END      = 16'hFE00;
    localparam logic [ADDR_W-1:0] RSVD_BASE     = 16'hFEA0;
    localparam logic [ADDR_W-1:0] RSVD_END      = 16'hFEFF;
    localparam logic [ADDR_W-1:0] MIRROR_OFS    = 16'h2000;
    localparam int                SEL_BIT       = 8;

    // Control write data decode.
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam logic [3:0] RAM_EN_KEY  = 4'hA;
    localparam logic [BANK_W-1:0] BANK_RESET = 4'd1;

    // Access kind.
    localparam logic FUNC_WRITE = 1'b1;

    // Where a decoded access goes.
    typedef enum logic [TARGET_W-1:0] {
        TGT_ROM  = 3'd0,
        TGT_CART = 3'd1,
        TGT_MAIN = 3'd2,
        TGT_CTRL = 3'd3,
        TGT_DROP = 3'd4
    } target_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rbm_req_if.sv
// Request channel of the ROM bank mapper: one bus access per item.
// Depends on rbm_pkg for field widths.
`default_nettype none

interface rbm_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [rbm_pkg::ADDR_W-1:0]    access_addr;
    logic [rbm_pkg::DATA_W-1:0]    write_data;

    modport source (output valid, output func, output access_addr, output write_data,
                    input ready);
    modport sink   (input valid, input func, input access_addr, input write_data,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rbm_rsp_if.sv
// Result channel of the ROM bank mapper: one decoded access per item.
// Depends on rbm_pkg for field widths.
`default_nettype none

interface rbm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [rbm_pkg::TARGET_W-1:0]      target;
    logic [rbm_pkg::MEM_ADDR_W-1:0]    mem_addr;
    logic                              mirror_valid;
    logic [rbm_pkg::ADDR_W-1:0]        mirror_addr;
    logic [rbm_pkg::DATA_W-1:0]        read_data;

    modport source (output valid, output target, output mem_addr, output mirror_valid,
                    output mirror_addr, output read_data, input ready);
    modport sink   (input valid, input target, input mem_addr, input mirror_valid,
                    input mirror_addr, input read_data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rom_bank_mapper_with_cart_ram_top.sv
// ROM bank mapper with 512-byte cartridge RAM, top level.
// Depends on rbm_pkg, rbm_req_if, rbm_rsp_if and the assertion macro header.
//
// Usage:
//   req carries one bus access per item (func, access_addr, write_data); rsp
//   carries one decoded result per item (target, mem_addr, mirror_valid,
//   mirror_addr, read_data). Items flow through an input register and a
//   result register; the result shows valid on rsp as the item moves into
//   the result register. One item is accepted every cycle unless rsp stalls.
//   Control writes (RAM enable, ROM bank) and cartridge RAM writes take
//   effect as the item leaves the input register, so the next item already
//   sees them. Cartridge RAM reads use the registered read port of the RAM.
//   After reset the cartridge RAM is cleared by a pass over all 512 bytes,
//   one byte a cycle; req.ready stays low during that pass. The RAM enable
//   resets to disabled and the ROM bank to 1.
//   When rsp stalls, the result register holds its item and the input
//   register still takes one more; req.ready then drops until rsp moves.
`default_nettype none

`include "rom_bank_mapper_with_cart_ram_top_defines.svh"

module rom_bank_mapper_with_cart_ram_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    rbm_req_if.sink    req,
    rbm_rsp_if.source  rsp
);

    // Clearing pass counter; the top bit set means the pass is done.
    logic [rbm_pkg::RAM_AW:0]            clr_cnt_reg;
    logic                                clear_active;

    // Input register.
    logic                                s1_valid_reg;
    logic                                s1_func_reg;
    logic [rbm_pkg::ADDR_W-1:0]          s1_addr_reg;
    logic [rbm_pkg::DATA_W-1:0]          s1_data_reg;

    // Mapper state.
    logic                                ram_enable_reg;
    logic                                ram_enable_next;
    logic [rbm_pkg::BANK_W-1:0]          rom_bank_reg;
    logic [rbm_pkg::BANK_W-1:0]          rom_bank_next;

    // Result register.
    logic                                out_valid_reg;
    rbm_pkg::target_t                    out_target_reg;
    logic [rbm_pkg::MEM_ADDR_W-1:0]      out_maddr_reg;
    logic                                out_mvalid_reg;
    logic [rbm_pkg::ADDR_W-1:0]          out_mirror_reg;
    logic                                out_cart_rd_reg;
    logic [rbm_pkg::DATA_W-1:0]          rdata_reg;

    // Cartridge RAM.
    logic [rbm_pkg::DATA_W-1:0]          cart_ram [rbm_pkg::RAM_DEPTH];

    // Decode results of the item in the input register.
    rbm_pkg::target_t                    dec_target;
    logic [rbm_pkg::MEM_ADDR_W-1:0]      dec_maddr;
    logic                                dec_mvalid;
    logic [rbm_pkg::ADDR_W-1:0]          dec_mirror;
    logic                                dec_cart_rd;
    logic                                dec_cart_wr;
    logic                                s1_adv;
    logic                                s1_in_cart;
    logic [rbm_pkg::RAM_AW-1:0]          s1_ridx;
    logic                                ram_we;
    logic [rbm_pkg::RAM_AW-1:0]          ram_waddr;
    logic [rbm_pkg::DATA_W-1:0]          ram_wdata;

    // Handshake: the input register advances when the result register is free.
    assign clear_active = !clr_cnt_reg[rbm_pkg::RAM_AW];
    assign s1_adv       = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready    = !clear_active && (!s1_valid_reg || s1_adv);

    // Cartridge RAM window test and index.
    assign s1_in_cart = (s1_addr_reg >= rbm_pkg::CART_BASE)
                     && (s1_addr_reg < rbm_pkg::CART_BASE
                         + rbm_pkg::ADDR_W'(rbm_pkg::RAM_DEPTH));
    assign s1_ridx    = s1_addr_reg[rbm_pkg::RAM_AW-1:0];

    // Decode the access and compute the next mapper state.
    always_comb
    begin
        dec_target      = rbm_pkg::TGT_MAIN;
        dec_maddr       = rbm_pkg::MEM_ADDR_W'(s1_addr_reg);
        dec_mvalid      = 1'b0;
        dec_mirror      = '0;
        dec_cart_rd     = 1'b0;
        dec_cart_wr     = 1'b0;
        ram_enable_next = ram_enable_reg;
        rom_bank_next   = rom_bank_reg;
        if (s1_func_reg != rbm_pkg::FUNC_WRITE)
        begin
            if (s1_addr_reg >= rbm_pkg::ROM_WIN_BASE && s1_addr_reg < rbm_pkg::ROM_WIN_END)
            begin
                dec_target = rbm_pkg::TGT_ROM;
                dec_maddr  = {rom_bank_reg, s1_addr_reg[rbm_pkg::BANK_OFS_W-1:0]};
            end
            else if (s1_in_cart)
            begin
                dec_target  = rbm_pkg::TGT_CART;
                dec_cart_rd = 1'b1;
            end
        end
        else
        begin
            if (s1_addr_reg < rbm_pkg::BANK_SEL_BASE && !s1_addr_reg[rbm_pkg::SEL_BIT])
            begin
                dec_target      = rbm_pkg::TGT_CTRL;
                ram_enable_next = (s1_data_reg[3:0] & rbm_pkg::NIBBLE_MASK)
                               == rbm_pkg::RAM_EN_KEY;
            end
            else if (s1_addr_reg >= rbm_pkg::BANK_SEL_BASE
                     && s1_addr_reg < rbm_pkg::ROM_WIN_BASE)
            begin
                if (s1_addr_reg[rbm_pkg::SEL_BIT])
                begin
                    dec_target = rbm_pkg::TGT_CTRL;
                    // Bank zero selects bank one.
                    if (s1_data_reg[rbm_pkg::BANK_W-1:0] == '0)
                        rom_bank_next = rbm_pkg::BANK_RESET;
                    else
                        rom_bank_next = s1_data_reg[rbm_pkg::BANK_W-1:0];
                end
                else
                begin
                    dec_target = rbm_pkg::TGT_DROP;
                end
            end
            else if (s1_in_cart)
            begin
                dec_target  = rbm_pkg::TGT_CART;
                dec_cart_wr = ram_enable_reg;
            end
            else if (s1_addr_reg >= rbm_pkg::ECHO_BASE && s1_addr_reg < rbm_pkg::ECHO_END)
            begin
                dec_mvalid = 1'b1;
                dec_mirror = s1_addr_reg - rbm_pkg::MIRROR_OFS;
            end
            else if (s1_addr_reg >= rbm_pkg::RSVD_BASE && s1_addr_reg < rbm_pkg::RSVD_END)
            begin
                dec_target = rbm_pkg::TGT_DROP;
            end
        end
    end

    // RAM write port: the clearing pass or an enabled cartridge write.
    assign ram_we    = clear_active || (s1_adv && dec_cart_wr);
    assign ram_waddr = clear_active ? clr_cnt_reg[rbm_pkg::RAM_AW-1:0] : s1_ridx;
    assign ram_wdata = clear_active ? '0 : s1_data_reg;

    // Cartridge RAM with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ram_we)
            cart_ram[ram_waddr] <= ram_wdata;
        if (s1_adv && dec_cart_rd)
            rdata_reg <= cart_ram[s1_ridx];
    end

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clear_active)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // Control state and stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            ram_enable_reg <= 1'b0;
            rom_bank_reg   <= rbm_pkg::BANK_RESET;
        end
        else
        begin
            if (req.valid && req.ready)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (s1_adv)
            begin
                ram_enable_reg <= ram_enable_next;
                rom_bank_reg   <= rom_bank_next;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_func_reg <= req.func;
            s1_addr_reg <= req.access_addr;
            s1_data_reg <= req.write_data;
        end
        if (s1_adv)
        begin
            out_target_reg  <= dec_target;
            out_maddr_reg   <= dec_maddr;
            out_mvalid_reg  <= dec_mvalid;
            out_mirror_reg  <= dec_mirror;
            out_cart_rd_reg <= dec_cart_rd;
        end
    end

    // Result channel.
    assign rsp.valid        = out_valid_reg;
    assign rsp.target       = out_target_reg;
    assign rsp.mem_addr     = out_maddr_reg;
    assign rsp.mirror_valid = out_mvalid_reg;
    assign rsp.mirror_addr  = out_mirror_reg;
    assign rsp.read_data    = out_cart_rd_reg ? rdata_reg : '0;

    // Checks on the mapper's own logic.
    `RBM_ASSERT_IMPL(a_bank_nonzero, 1'b1, rom_bank_reg != '0)
    `RBM_ASSERT_IMPL(a_no_accept_in_clear, clear_active, !req.ready)
    `RBM_ASSERT_IMPL(a_rdata_only_cart, rsp.valid && rsp.target != rbm_pkg::TGT_CART, rsp.read_data == '0)
    `RBM_ASSERT_IMPL(a_mirror_is_main, rsp.valid && rsp.mirror_valid, rsp.target == rbm_pkg::TGT_MAIN)

endmodule

`default_nettype wire

FILE: tb/rom_bank_mapper_with_cart_ram_top_test.sv
// Testbench for the ROM bank mapper with cartridge RAM: directed and random bus accesses.
// Uses rbm_pkg, rbm_req_if and rbm_rsp_if; checks every decoded item against an own predictor.
// Depends on the top level rom_bank_mapper_with_cart_ram_top.

module rom_bank_mapper_with_cart_ram_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbm_pkg::*;

    localparam logic        FUNC_READ     = !FUNC_WRITE;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_ITEMS  = 1400;
    localparam int unsigned HOLD_AFTER    = 300;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned DRAIN_CYCLES  = 10;

    // One bus access as offered on the request channel.
    typedef struct packed {
        logic              func;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } bus_access_t;

    // One decoded access as returned on the result channel.
    typedef struct {
        target_t               target;
        logic [MEM_ADDR_W-1:0] mem_addr;
        logic                  mirror_valid;
        logic [ADDR_W-1:0]     mirror_addr;
        logic [DATA_W-1:0]     read_data;
    } decoded_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rbm_req_if req();
    rbm_rsp_if rsp();

    rom_bank_mapper_with_cart_ram_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Predicted mapper state.
    logic              ram_on     = 1'b0;
    logic [BANK_W-1:0] rom_bank_q = BANK_RESET;
    logic [DATA_W-1:0] cart_bytes [RAM_DEPTH] = '{default: '0};

    bus_access_t pending_accesses[$];
    decoded_t    predicted_decodes[$];
    bus_access_t on_bus;
    decoded_t    decoded;

    int unsigned accepted_accesses = 0;
    int unsigned mismatch_count    = 0;
    int unsigned cycle_count       = 0;
    int unsigned send_wait         = 0;
    int unsigned rsp_wait          = 0;
    bit          send_calm         = 1'b0;
    bit          recv_calm         = 1'b0;
    logic        rsp_hold          = 1'b0;

    // Clock, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decode one access and update the predicted state the way the mapper does.
    task automatic decode_access(input bus_access_t acc, output decoded_t res);
        logic [ADDR_W-1:0] a;
        logic              sel;
        logic              in_cart;
        logic [RAM_AW-1:0] idx;
        a = acc.addr;
        sel = a[SEL_BIT];
        in_cart = (a >= CART_BASE) && (int'(a) < int'(CART_BASE) + RAM_DEPTH);
        idx = RAM_AW'(a - CART_BASE);
        res.target = TGT_MAIN;
        res.mem_addr = MEM_ADDR_W'(a);
        res.mirror_valid = 1'b0;
        res.mirror_addr = '0;
        res.read_data = '0;
        if (acc.func != FUNC_WRITE)
        begin
            // Reads hit the banked ROM window or the cartridge RAM, else main memory.
            if (a >= ROM_WIN_BASE && a < ROM_WIN_END)
            begin
                res.target = TGT_ROM;
                res.mem_addr = MEM_ADDR_W'(int'(rom_bank_q) * BANK_BYTES
                                           + int'(a - ROM_WIN_BASE));
            end
            else if (in_cart)
            begin
                res.target = TGT_CART;
                res.read_data = cart_bytes[idx];
            end
        end
        else if (a < BANK_SEL_BASE && !sel)
        begin
            res.target = TGT_CTRL;
            ram_on = ((acc.data[3:0] & NIBBLE_MASK) == RAM_EN_KEY);
        end
        else if (a >= BANK_SEL_BASE && a < ROM_WIN_BASE)
        begin
            // Bank select needs the select bit; a zero bank reads as bank one.
            if (sel)
            begin
                res.target = TGT_CTRL;
                rom_bank_q = (acc.data[BANK_W-1:0] == '0) ? BANK_RESET : acc.data[BANK_W-1:0];
            end
            else
                res.target = TGT_DROP;
        end
        else if (in_cart)
        begin
            res.target = TGT_CART;
            if (ram_on)
                cart_bytes[idx] = acc.data;
        end
        else if (a >= ECHO_BASE && a < ECHO_END)
        begin
            res.mirror_valid = 1'b1;
            res.mirror_addr = a - MIRROR_OFS;
        end
        else if (a >= RSVD_BASE && a < RSVD_END)
            res.target = TGT_DROP;
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_access(input logic func, input logic [ADDR_W-1:0] addr,
                                        input logic [DATA_W-1:0] data);
        bus_access_t acc;
        acc.func = func;
        acc.addr = addr;
        acc.data = data;
        pending_accesses.push_back(acc);
    endfunction

    // Random access, weighted toward the decoded regions and the control writes.
    function automatic bus_access_t random_access();
        bus_access_t acc;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        acc.func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
        acc.addr = ADDR_W'($urandom_range(0, 16'hFFFF));
        acc.data = DATA_W'($urandom_range(0, 255));
        if (pick < 12)
        begin
            // RAM enable writes, half of them with the enable key.
            acc.func = FUNC_WRITE;
            acc.addr = ADDR_W'($urandom_range(0, 16'h1FFF));
            acc.addr[SEL_BIT] = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 1))
                acc.data[3:0] = RAM_EN_KEY;
        end
        else if (pick < 22)
        begin
            acc.func = FUNC_WRITE;
            acc.addr = ADDR_W'($urandom_range(16'h2000, 16'h3FFF));
            acc.addr[SEL_BIT] = ($urandom_range(0, 7) != 0);
        end
        else if (pick < 40)
        begin
            acc.func = ($urandom_range(0, 7) == 0) ? FUNC_WRITE : FUNC_READ;
            acc.addr = ADDR_W'($urandom_range(16'h4000, 16'h7FFF));
        end
        else if (pick < 65)
        begin
            // A few hot entries so that reads often return written bytes.
            acc.addr = CART_BASE + ADDR_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                           : $urandom_range(0, RAM_DEPTH - 1));
        end
        else if (pick < 75)
        begin
            acc.func = ($urandom_range(0, 3) != 0) ? FUNC_WRITE : FUNC_READ;
            acc.addr = ADDR_W'($urandom_range(32'(ECHO_BASE), 32'(ECHO_END) - 1));
        end
        else if (pick < 83)
            acc.addr = ADDR_W'($urandom_range(16'hFE80, 16'hFFFF));
        return acc;
    endfunction

    // Request driver: offers queued items with a random wait before each one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                decode_access(on_bus, decoded);
                predicted_decodes.push_back(decoded);
                accepted_accesses++;
            end
            if (!req.valid || req.ready)
            begin
                if (send_wait != 0)
                begin
                    send_wait = send_wait - 1;
                    req.valid <= 1'b0;
                end
                else if (pending_accesses.size() != 0)
                begin
                    on_bus = pending_accesses.pop_front();
                    req.valid <= 1'b1;
                    req.func <= on_bus.func;
                    req.access_addr <= on_bus.addr;
                    req.write_data <= on_bus.data;
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_wait = send_calm ? 0 : $urandom_range(0, 17);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each item and stalls at random after it.
    always @(posedge clk)
    begin
        decoded_t want;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_wait = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (predicted_decodes.size() == 0)
                    report_mismatch("unexpected item, target", 32'(rsp.target), 0);
                else
                begin
                    want = predicted_decodes.pop_front();
                    if (rsp.target !== want.target)
                        report_mismatch("target", 32'(rsp.target), 32'(want.target));
                    if (rsp.mem_addr !== want.mem_addr)
                        report_mismatch("mem_addr", 32'(rsp.mem_addr), 32'(want.mem_addr));
                    if (rsp.mirror_valid !== want.mirror_valid)
                        report_mismatch("mirror_valid", 32'(rsp.mirror_valid),
                                        32'(want.mirror_valid));
                    if (rsp.mirror_addr !== want.mirror_addr)
                        report_mismatch("mirror_addr", 32'(rsp.mirror_addr),
                                        32'(want.mirror_addr));
                    if (rsp.read_data !== want.read_data)
                        report_mismatch("read_data", 32'(rsp.read_data), 32'(want.read_data));
                end
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                rsp_wait = recv_calm ? 0 : $urandom_range(0, 17);
            end
            else if (rsp_wait != 0)
                rsp_wait = rsp_wait - 1;
            rsp.ready <= !rsp_hold && (rsp_wait == 0);
        end
    end

    // Long result stall while the driver keeps offering, so the input side backs up.
    initial
    begin
        while (accepted_accesses < HOLD_AFTER)
            @(negedge clk);
        @(posedge clk);
        rsp_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Cycle limit on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        req.valid = 1'b0;
        req.func = FUNC_READ;
        req.access_addr = '0;
        req.write_data = '0;
        rsp.ready = 1'b0;

        // Region edges with the reset bank and a cleared, disabled cartridge RAM.
        push_access(FUNC_READ, 16'h0000, 8'h00);
        push_access(FUNC_READ, 16'h4000, 8'hFF);
        push_access(FUNC_READ, 16'h8000, 8'h00);
        push_access(FUNC_READ, 16'hA000, 8'h00);
        push_access(FUNC_WRITE, 16'hA000, 8'h77);
        push_access(FUNC_READ, 16'hA000, 8'h00);
        // Enable writes, the select bit set below the bank range, and cartridge RAM writes.
        push_access(FUNC_WRITE, 16'h1EFF, 8'h0A);
        push_access(FUNC_WRITE, 16'h0100, 8'h00);
        push_access(FUNC_WRITE, 16'hA1FF, 8'hFF);
        push_access(FUNC_READ, 16'hA1FF, 8'h00);
        push_access(FUNC_WRITE, 16'h0000, 8'hA0);
        push_access(FUNC_WRITE, 16'hA1FF, 8'h00);
        push_access(FUNC_READ, 16'hA1FF, 8'h00);
        push_access(FUNC_READ, 16'hA200, 8'h00);
        // Bank select: top bank, the select bit clear, and zero turned into one.
        push_access(FUNC_WRITE, 16'h3FFF, 8'hFF);
        push_access(FUNC_WRITE, 16'h2000, 8'h05);
        push_access(FUNC_READ, 16'h7FFF, 8'h00);
        push_access(FUNC_WRITE, 16'h2100, 8'hF0);
        push_access(FUNC_READ, 16'h7FFF, 8'h00);
        // Writes in the ROM window, echo range edges and the restricted area.
        push_access(FUNC_WRITE, 16'h4000, 8'h12);
        push_access(FUNC_WRITE, 16'hE000, 8'h34);
        push_access(FUNC_WRITE, 16'hFDFF, 8'h56);
        push_access(FUNC_WRITE, 16'hFE00, 8'h78);
        push_access(FUNC_WRITE, 16'hFEA0, 8'h9A);
        push_access(FUNC_WRITE, 16'hFEFE, 8'hBC);
        push_access(FUNC_WRITE, 16'hFFFF, 8'hFF);
        push_access(FUNC_READ, 16'hFFFF, 8'hFF);
        repeat (RANDOM_ITEMS) pending_accesses.push_back(random_access());

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_accesses.size() != 0 || req.valid || predicted_decodes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: rom_bank_mapper_with_cart_ram_top.f
+incdir+hw/rtl
hw/rtl/rbm_pkg.sv
hw/rtl/rbm_req_if.sv
hw/rtl/rbm_rsp_if.sv
hw/rtl/rom_bank_mapper_with_cart_ram_top.sv
tb/rom_bank_mapper_with_cart_ram_top_test.sv
